FILE: rtl/bros_pkg.sv
// ----------------------------------------------------------------------------
// bros_pkg: shared constants and helpers for border radius overlap scaling.
// Holds the field widths, the unity scale and one restoring division step.
// ----------------------------------------------------------------------------
package bros_pkg;

  localparam int unsigned LenW      = 16;
  localparam int unsigned FracW     = 16;
  localparam int unsigned ScaleW    = FracW + 1;
  localparam int unsigned SumW      = LenW + 1;
  localparam int unsigned NumRad    = 8;
  localparam int unsigned NumSide   = 4;
  localparam int unsigned StepsPerSt = 2;
  localparam int unsigned DivStages = FracW / StepsPerSt;
  localparam logic [ScaleW-1:0] ScaleOne = ScaleW'(1) << FracW;

  typedef logic [LenW-1:0] len_t;
  typedef logic [SumW-1:0] sum_t;
  typedef logic [NumRad-1:0][LenW-1:0] rad_t;

  // One restoring step: returns the quotient bit above the new remainder.
  function automatic logic [SumW:0] div_step(input sum_t rem, input sum_t dvs);
    logic [SumW:0] t;
    logic [SumW:0] r;
    t = {rem, 1'b0};
    r = '0;
    if (t >= {1'b0, dvs}) begin
      r = {1'b1, SumW'(t - {1'b0, dvs})};
    end else begin
      r = {1'b0, t[SumW-1:0]};
    end
    return r;
  endfunction

endpackage

FILE: rtl/bros_div.sv
// ----------------------------------------------------------------------------
// bros_div: pipelined restoring divider.
// Forms (edge << FracW) / sum for edge < sum, two quotient bits per stage.
// ----------------------------------------------------------------------------
module bros_div import bros_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  len_t               edge_len_i,
  input  sum_t               sum_i,
  output logic [FracW-1:0]   quo_o
);

  sum_t             rem_q [DivStages];
  sum_t             dvs_q [DivStages];
  logic [FracW-1:0] quo_q [DivStages];
  sum_t             rem_d [DivStages];
  logic [FracW-1:0] quo_d [DivStages];

  always_comb begin
    for (int k = 0; k < DivStages; k++) begin
      sum_t             r;
      sum_t             d;
      logic [FracW-1:0] q;
      logic [SumW:0]    s;
      if (k == 0) begin
        r = SumW'(edge_len_i);
        d = sum_i;
        q = '0;
      end else begin
        r = rem_q[k-1];
        d = dvs_q[k-1];
        q = quo_q[k-1];
      end
      for (int j = 0; j < StepsPerSt; j++) begin
        s = div_step(r, d);
        r = s[SumW-1:0];
        q = {q[FracW-2:0], s[SumW]};
      end
      rem_d[k] = r;
      quo_d[k] = q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DivStages; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
        dvs_q[k] <= (k == 0) ? sum_i : dvs_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign quo_o = quo_q[DivStages-1];

endmodule

FILE: rtl/border_radius_overlap_scale.sv
// ----------------------------------------------------------------------------
// border_radius_overlap_scale: scales corner radii that overlap a box edge.
// Sums radii per side, divides edge by sum and applies the smallest ratio.
// ----------------------------------------------------------------------------
// One box enters per clock while in_stall_o is low and passes the input,
// divider, scale and output registers. The depth is set by the four side
// dividers, which resolve two quotient bits per stage. The whole pipeline
// holds while a result waits under out_stall_i; in_stall_o follows it in the same cycle.
module border_radius_overlap_scale import bros_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  len_t              box_width_i,
  input  len_t              box_height_i,
  input  len_t              rad_x_top_left_i,
  input  len_t              rad_y_top_left_i,
  input  len_t              rad_x_top_right_i,
  input  len_t              rad_y_top_right_i,
  input  len_t              rad_x_bottom_right_i,
  input  len_t              rad_y_bottom_right_i,
  input  len_t              rad_x_bottom_left_i,
  input  len_t              rad_y_bottom_left_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output len_t              out_x_top_left_o,
  output len_t              out_y_top_left_o,
  output len_t              out_x_top_right_o,
  output len_t              out_y_top_right_o,
  output len_t              out_x_bottom_right_o,
  output len_t              out_y_bottom_right_o,
  output len_t              out_x_bottom_left_o,
  output len_t              out_y_bottom_left_o,
  output logic [ScaleW-1:0] scale_factor_o,
  output logic              was_scaled_o
);

  localparam int unsigned Depth = DivStages + 3;
  localparam int unsigned DivOut = DivStages + 1;

  logic adv;
  logic [Depth:1] vld_q;

  len_t w1_q, h1_q;
  rad_t rad_q [DivOut:1];
  logic [NumSide-1:0] ovf_q [DivOut:1];
  sum_t sum_q [NumSide];
  logic [FracW-1:0] quo [NumSide];
  len_t edge_sel [NumSide];

  rad_t rad10_q;
  logic [ScaleW-1:0] scale10_q, scale10_d;
  rad_t rad_in;
  sum_t sum_d [NumSide];

  rad_t out_q;
  logic [ScaleW-1:0] scale_q;
  logic scaled_q;

  assign adv = !vld_q[Depth] || !out_stall_i;
  assign in_stall_o = !adv;

  assign rad_in = {rad_y_bottom_left_i, rad_x_bottom_left_i, rad_y_bottom_right_i,
                   rad_x_bottom_right_i, rad_y_top_right_i, rad_x_top_right_i,
                   rad_y_top_left_i, rad_x_top_left_i};

  always_comb begin
    sum_d[0] = SumW'(rad_in[0]) + SumW'(rad_in[2]);
    sum_d[1] = SumW'(rad_in[6]) + SumW'(rad_in[4]);
    sum_d[2] = SumW'(rad_in[1]) + SumW'(rad_in[7]);
    sum_d[3] = SumW'(rad_in[3]) + SumW'(rad_in[5]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-1:1], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      w1_q     <= box_width_i;
      h1_q     <= box_height_i;
      rad_q[1] <= rad_in;
      ovf_q[1] <= {sum_d[3] > SumW'(box_height_i), sum_d[2] > SumW'(box_height_i),
                   sum_d[1] > SumW'(box_width_i), sum_d[0] > SumW'(box_width_i)};
      for (int s = 0; s < NumSide; s++) begin
        sum_q[s] <= sum_d[s];
      end
      for (int k = 2; k <= DivOut; k++) begin
        rad_q[k] <= rad_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
      rad10_q   <= rad_q[DivOut];
      scale10_q <= scale10_d;
    end
  end

  assign edge_sel[0] = w1_q;
  assign edge_sel[1] = w1_q;
  assign edge_sel[2] = h1_q;
  assign edge_sel[3] = h1_q;

  for (genvar s = 0; s < NumSide; s++) begin : g_div
    bros_div u_div (
      .clk_i      (clk_i),
      .en_i       (adv),
      .edge_len_i (edge_sel[s]),
      .sum_i      (sum_q[s]),
      .quo_o      (quo[s])
    );
  end

  always_comb begin
    scale10_d = ScaleOne;
    for (int s = 0; s < NumSide; s++) begin
      if (ovf_q[DivOut][s] && (ScaleW'(quo[s]) < scale10_d)) begin
        scale10_d = ScaleW'(quo[s]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NumRad; i++) begin
        if (scale10_q != ScaleOne) begin
          out_q[i] <= LenW'((32'(rad10_q[i]) * 32'(scale10_q[FracW-1:0])) >> FracW);
        end else begin
          out_q[i] <= rad10_q[i];
        end
      end
      scale_q  <= scale10_q;
      scaled_q <= scale10_q != ScaleOne;
    end
  end

  assign out_valid_o          = vld_q[Depth];
  assign out_x_top_left_o     = out_q[0];
  assign out_y_top_left_o     = out_q[1];
  assign out_x_top_right_o    = out_q[2];
  assign out_y_top_right_o    = out_q[3];
  assign out_x_bottom_right_o = out_q[4];
  assign out_y_bottom_right_o = out_q[5];
  assign out_x_bottom_left_o  = out_q[6];
  assign out_y_bottom_left_o  = out_q[7];
  assign scale_factor_o       = scale_q;
  assign was_scaled_o         = scaled_q;

  a_scale_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (was_scaled_o == (scale_factor_o != ScaleOne)))
    else $error("scale flag disagrees with scale factor");

  a_scale_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (scale_factor_o <= ScaleOne))
    else $error("scale factor above one");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> ($stable(vld_q) && out_valid_o))
    else $error("pipeline moved while stalled");

endmodule

FILE: sim/border_radius_overlap_scale_checker.sv
// ----------------------------------------------------------------------------
// Border radius overlap scale checker
// Watches both channels, predicts the scaled radii of every accepted box
// and compares each accepted result field by field with the oldest one.
// ----------------------------------------------------------------------------
module border_radius_overlap_scale_checker import bros_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  len_t              box_width_i,
  input  len_t              box_height_i,
  input  rad_t              rad_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  rad_t              out_rad_i,
  input  logic [ScaleW-1:0] scale_factor_i,
  input  logic              was_scaled_i,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    rad_t              rad;
    logic [ScaleW-1:0] scale;
    logic              scaled;
  } corner_result_t;

  corner_result_t scaled_radii_q[$];

  function automatic logic [63:0] narrow_scale(logic [63:0] scale, logic [63:0] edge_len,
                                               logic [63:0] side_sum);
    logic [63:0] ratio;
    if (side_sum <= edge_len) return scale;
    ratio = (edge_len << FracW) / side_sum;
    return (ratio < scale) ? ratio : scale;
  endfunction

  function automatic corner_result_t scale_corners(len_t w, len_t h, rad_t r);
    corner_result_t res;
    logic [63:0] s;
    s = 64'(ScaleOne);
    s = narrow_scale(s, 64'(w), 64'(r[0]) + 64'(r[2]));
    s = narrow_scale(s, 64'(w), 64'(r[6]) + 64'(r[4]));
    s = narrow_scale(s, 64'(h), 64'(r[1]) + 64'(r[7]));
    s = narrow_scale(s, 64'(h), 64'(r[3]) + 64'(r[5]));
    res.scaled = s < 64'(ScaleOne);
    for (int i = 0; i < NumRad; i++) begin
      res.rad[i] = res.scaled ? LenW'((64'(r[i]) * s) >> FracW) : r[i];
    end
    res.scale = ScaleW'(s);
    return res;
  endfunction

  assign pending_o = scaled_radii_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    corner_result_t exp_r;
    int errs;
    if (!rst_ni) begin
      fail_count_o <= 0;
      scaled_radii_q.delete();
    end else begin
      errs = 0;
      if (in_valid_i && !in_stall_i) begin
        scaled_radii_q.push_back(scale_corners(box_width_i, box_height_i, rad_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (scaled_radii_q.size() == 0) begin
          $display("%0t: unexpected transaction, actual %h %h %b", $time, out_rad_i,
                   scale_factor_i, was_scaled_i);
          errs = errs + 1;
        end else begin
          exp_r = scaled_radii_q.pop_front();
          for (int i = 0; i < NumRad; i++) begin
            if (out_rad_i[i] !== exp_r.rad[i]) begin
              $display("%0t: radius %0d expected %h actual %h", $time, i, exp_r.rad[i],
                       out_rad_i[i]);
              errs = errs + 1;
            end
          end
          if (scale_factor_i !== exp_r.scale) begin
            $display("%0t: scale_factor expected %h actual %h", $time, exp_r.scale,
                     scale_factor_i);
            errs = errs + 1;
          end
          if (was_scaled_i !== exp_r.scaled) begin
            $display("%0t: was_scaled expected %b actual %b", $time, exp_r.scaled,
                     was_scaled_i);
            errs = errs + 1;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
    end
  end

endmodule

FILE: sim/border_radius_overlap_scale_tb.sv
// ----------------------------------------------------------------------------
// Border radius overlap scale testbench
// Drives directed and random boxes with random idling on both channels and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module border_radius_overlap_scale_tb import bros_pkg::*; ();

  localparam int WatchdogLimit = 5000;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  len_t              box_width_i;
  len_t              box_height_i;
  rad_t              rad_i;
  logic              out_valid_o;
  logic              out_stall_i;
  rad_t              out_rad_o;
  logic [ScaleW-1:0] scale_factor_o;
  logic              was_scaled_o;
  int                fail_count;
  int                pending;
  logic              sink_idle_ok;
  logic              hold_off_req;
  int                idle_cycles;

  border_radius_overlap_scale u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .box_width_i, .box_height_i,
    .rad_x_top_left_i(rad_i[0]), .rad_y_top_left_i(rad_i[1]),
    .rad_x_top_right_i(rad_i[2]), .rad_y_top_right_i(rad_i[3]),
    .rad_x_bottom_right_i(rad_i[4]), .rad_y_bottom_right_i(rad_i[5]),
    .rad_x_bottom_left_i(rad_i[6]), .rad_y_bottom_left_i(rad_i[7]),
    .out_valid_o, .out_stall_i,
    .out_x_top_left_o(out_rad_o[0]), .out_y_top_left_o(out_rad_o[1]),
    .out_x_top_right_o(out_rad_o[2]), .out_y_top_right_o(out_rad_o[3]),
    .out_x_bottom_right_o(out_rad_o[4]), .out_y_bottom_right_o(out_rad_o[5]),
    .out_x_bottom_left_o(out_rad_o[6]), .out_y_bottom_left_o(out_rad_o[7]),
    .scale_factor_o, .was_scaled_o
  );

  border_radius_overlap_scale_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .box_width_i, .box_height_i,
    .rad_i, .out_valid_i(out_valid_o), .out_stall_i, .out_rad_i(out_rad_o),
    .scale_factor_i(scale_factor_o), .was_scaled_i(was_scaled_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("border_radius_overlap_scale_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stall bursts, and long hold-offs while they are requested.
  initial begin
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (60) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (sink_idle_ok && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 19);
        out_stall_i <= 1'b1;
        repeat (n - 1) @(posedge clk_i);
        @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic len_t rand_len(int mode);
    case (mode)
      0: return len_t'($urandom);
      1: return len_t'($urandom_range(0, 255));
      2: return len_t'($urandom_range(0, 4095));
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  task automatic send_box(len_t w, len_t h, rad_t r, bit allow_gap);
    int n;
    if (allow_gap && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 19);
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    box_width_i  <= w;
    box_height_i <= h;
    rad_i        <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_random(int count, bit allow_gap);
    rad_t r;
    len_t w;
    len_t h;
    int m;
    for (int k = 0; k < count; k++) begin
      m = $urandom_range(0, 3);
      for (int i = 0; i < NumRad; i++) r[i] = rand_len($urandom_range(0, 3) == 0 ? 0 : m);
      w = rand_len($urandom_range(0, 2));
      h = rand_len($urandom_range(0, 2));
      if ($urandom_range(0, 9) == 0) w = '0;
      if ($urandom_range(0, 9) == 0) h = r[3] + r[5];
      send_box(w, h, r, allow_gap);
    end
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    rad_t r;
    in_valid_i   = 1'b0;
    box_width_i  = '0;
    box_height_i = '0;
    rad_i        = '0;
    sink_idle_ok = 1'b0;
    hold_off_req = 1'b0;
    rst_ni       = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_box('0, '0, '0, 0);
    send_box('1, '1, '1, 0);
    send_box('0, '0, '1, 0);
    send_box('1, '1, '0, 0);
    send_box('0, 16'd100, {8{16'd1}}, 0);
    r = '0; r[0] = 16'd60; r[2] = 16'd40;
    send_box(16'd100, 16'd100, r, 0);
    r[2] = 16'd41;
    send_box(16'd100, 16'd100, r, 0);
    r = '0; r[6] = 16'd300; r[4] = 16'd300;
    send_box(16'd200, 16'd500, r, 0);
    r = '0; r[1] = 16'd500; r[7] = 16'd500;
    send_box(16'd1000, 16'd100, r, 0);
    r = '0; r[3] = 16'hFFFF; r[5] = 16'h0001;
    send_box(16'd10, 16'h8000, r, 0);
    r = {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA};
    send_box(16'h1234, 16'hFEDC, r, 0);
    send_box(16'hAAAA, 16'h5555, ~r, 0);
    r = {16'd40, 16'd30, 16'd20, 16'd90, 16'd70, 16'd10, 16'd60, 16'd50};
    send_box(16'd100, 16'd100, r, 0);
    drain();

    sink_idle_ok = 1'b1;
    send_random(800, 1);

    hold_off_req <= 1'b1;
    send_random(40, 0);
    hold_off_req <= 1'b0;
    drain();
    repeat ($urandom_range(1, 19)) @(posedge clk_i);

    send_random(700, 1);
    sink_idle_ok = 1'b0;
    send_random(200, 0);
    drain();
    repeat (20) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("border_radius_overlap_scale_tb OK");
    end else begin
      $display("border_radius_overlap_scale_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/bros_pkg.sv
rtl/bros_div.sv
rtl/border_radius_overlap_scale.sv
sim/border_radius_overlap_scale_checker.sv
sim/border_radius_overlap_scale_tb.sv
